// File: rtl/hamming_encode_and_correct_top_defines.svh
// Assertion macros shared by the Hamming encode and correct RTL
`ifndef HAMMING_ENCODE_AND_CORRECT_TOP_DEFINES_SVH
`define HAMMING_ENCODE_AND_CORRECT_TOP_DEFINES_SVH

// Check that the consequent holds whenever the antecedent holds
`define HEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hec assertion failed: implication");

// Check that a condition never occurs
`define HEC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hec assertion failed: forbidden condition");

`endif

// File: rtl/hec_pkg.sv
// Shared constants, types and the parity-count function of the Hamming encode and correct block
`timescale 1ns / 1ps
`default_nettype none

package hec_pkg;

    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int MSG_W    = 57;
    localparam int CW_W     = 63;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CORRECTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] k;
        logic [POS_W-1:0] n;
    } cfg_t;

    function automatic int parity_count(input int k);
        int r;
        r = 0;
        for (int i = 0; i < 7; i++)
        begin
            if ((1 << r) < k + r + 1)
            begin
                r = r + 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hec_cfg.sv
// Data-bit count register with saturation and derived codeword length
`timescale 1ns / 1ps
`default_nettype none

module hec_cfg #(
    parameter int MAX_DATA_BITS = 57
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [hec_pkg::POS_W-1:0]  cfg_write_data,
    output hec_pkg::cfg_t                   cfg
);

    localparam int PW = hec_pkg::POS_W;
    localparam logic [PW-1:0] K_MAX   = PW'(MAX_DATA_BITS);
    localparam logic [PW-1:0] K_RESET = (MAX_DATA_BITS < 4) ? K_MAX : PW'(4);
    localparam logic [PW-1:0] N_RESET =
        K_RESET + PW'(hec_pkg::parity_count(int'(K_RESET)));

    hec_pkg::cfg_t cfg_reg;
    hec_pkg::cfg_t cfg_next;

    always_comb
    begin
        priority if (cfg_write_data == '0)
        begin
            cfg_next.k = PW'(1);
        end
        else if (cfg_write_data > K_MAX)
        begin
            cfg_next.k = K_MAX;
        end
        else
        begin
            cfg_next.k = cfg_write_data;
        end
        cfg_next.n = cfg_next.k + PW'(hec_pkg::parity_count(int'(cfg_next.k)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k <= K_RESET;
            cfg_reg.n <= N_RESET;
        end
        else if (cfg_write_en)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/hec_spread.sv
// First stage: place message at data positions or pass received; mask to length
`timescale 1ns / 1ps
`default_nettype none

module hec_spread #(
    parameter int MW = 57,
    parameter int NW = 63
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire hec_pkg::cfg_t              cfg,
    input  wire logic                       up_valid,
    output logic                            up_stall,
    input  wire logic                       opcode,
    input  wire logic [hec_pkg::MSG_W-1:0]  message,
    input  wire logic [hec_pkg::CW_W-1:0]   received,
    output logic                            down_valid,
    input  wire logic                       down_ready,
    output logic                            down_op,
    output logic [NW-1:0]                   down_word
);

    localparam int PW = hec_pkg::POS_W;

    logic          valid_reg;
    logic          op_reg;
    logic [NW-1:0] word_reg;
    logic [NW-1:0] word_next;
    logic [MW-1:0] k_mask;
    logic [NW-1:0] n_mask;
    logic [NW-1:0] spread;
    logic          take;

    always_comb
    begin
        for (int j = 0; j < MW; j++)
        begin
            k_mask[j] = (PW'(j) < cfg.k);
        end
        for (int i = 0; i < NW; i++)
        begin
            n_mask[i] = (PW'(i) < cfg.n);
        end
    end

    for (genvar p = 1; p <= NW; p++)
    begin : g_pos
        if ((p & (p - 1)) == 0)
        begin : g_par
            assign spread[p-1] = 1'b0;
        end
        else
        begin : g_dat
            localparam int D = p - 1 - $clog2(p + 1);
            assign spread[p-1] = message[D] & k_mask[D];
        end
    end

    assign word_next = ((opcode == hec_pkg::OP_ENCODE) ? spread : received[NW-1:0]) & n_mask;
    assign take      = !valid_reg || down_ready;
    assign up_stall  = !take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            op_reg   <= opcode;
            word_reg <= word_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_op    = op_reg;
    assign down_word  = word_reg;

endmodule

`default_nettype wire

// File: rtl/hec_syndrome.sv
// Second stage: XOR of the positions that hold a one
`timescale 1ns / 1ps
`default_nettype none

module hec_syndrome #(
    parameter int NW = 63
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire logic                       up_op,
    input  wire logic [NW-1:0]              up_word,
    output logic                            down_valid,
    input  wire logic                       down_ready,
    output logic                            down_op,
    output logic [NW-1:0]                   down_word,
    output logic [hec_pkg::POS_W-1:0]       down_syn
);

    localparam int PW = hec_pkg::POS_W;

    logic          valid_reg;
    logic          op_reg;
    logic [NW-1:0] word_reg;
    logic [PW-1:0] syn_reg;
    logic [PW-1:0] syn_next;
    logic [NW-1:0] sel [PW];
    logic          take;

    always_comb
    begin
        for (int i = 0; i < PW; i++)
        begin
            for (int p = 1; p <= NW; p++)
            begin
                sel[i][p-1] = up_word[p-1] & (((p >> i) & 1) == 1);
            end
            syn_next[i] = ^sel[i];
        end
    end

    assign take     = !valid_reg || down_ready;
    assign up_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            op_reg   <= up_op;
            word_reg <= up_word;
            syn_reg  <= syn_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_op    = op_reg;
    assign down_word  = word_reg;
    assign down_syn   = syn_reg;

endmodule

`default_nettype wire

// File: rtl/hec_correct.sv
// Third stage: insert parity bits or correct an in-range named bit; hold result word
`timescale 1ns / 1ps
`default_nettype none

module hec_correct #(
    parameter int NW = 63
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire hec_pkg::cfg_t                 cfg,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic                          up_op,
    input  wire logic [NW-1:0]                 up_word,
    input  wire logic [hec_pkg::POS_W-1:0]     up_syn,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hec_pkg::CW_W-1:0]           codeword,
    output logic [hec_pkg::POS_W-1:0]          error_position,
    output logic [hec_pkg::STATUS_W-1:0]       status
);

    localparam int PW = hec_pkg::POS_W;
    localparam int SW = hec_pkg::STATUS_W;

    logic          valid_reg;
    logic [NW-1:0] word_reg;
    logic [NW-1:0] word_next;
    logic [PW-1:0] err_reg;
    logic [PW-1:0] err_next;
    logic [SW-1:0] status_reg;
    logic [SW-1:0] status_next;
    logic [NW-1:0] parity;
    logic [NW-1:0] flip;
    logic          take;

    always_comb
    begin
        for (int p = 1; p <= NW; p++)
        begin
            flip[p-1]   = (up_syn == PW'(p));
            parity[p-1] = 1'b0;
        end
        for (int i = 0; i < PW; i++)
        begin
            if ((1 << i) <= NW)
            begin
                parity[(1 << i) - 1] = up_syn[i];
            end
        end
    end

    always_comb
    begin
        priority if (up_op == hec_pkg::OP_ENCODE)
        begin
            word_next   = up_word | parity;
            err_next    = '0;
            status_next = hec_pkg::STATUS_OK;
        end
        else if (up_syn == '0)
        begin
            word_next   = up_word;
            err_next    = '0;
            status_next = hec_pkg::STATUS_OK;
        end
        else if (up_syn <= cfg.n)
        begin
            word_next   = up_word ^ flip;
            err_next    = up_syn;
            status_next = hec_pkg::STATUS_CORRECTED;
        end
        else
        begin
            word_next   = up_word;
            err_next    = up_syn;
            status_next = hec_pkg::STATUS_RANGE;
        end
    end

    assign take     = !valid_reg || !out_stall;
    assign up_ready = take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && up_valid)
        begin
            word_reg   <= word_next;
            err_reg    <= err_next;
            status_reg <= status_next;
        end
    end

    assign out_valid      = valid_reg;
    assign codeword       = hec_pkg::CW_W'(word_reg);
    assign error_position = err_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// File: rtl/hamming_encode_and_correct_top.sv
// Top level of the pipelined Hamming single-error-correcting encoder and decoder
//
//  channel  direction  handshake              payload
//  input    in         in_valid / in_stall    opcode, message, received
//  output   out        out_valid / out_stall  codeword, error_position, status
//  config   in         cfg_write_en           cfg_write_data
//
//  One word per cycle sustained while out_stall is low; each stage below registers its result.
//  Stages: bit placement and masking, syndrome XOR tree, parity insert or bit flip.
//  Reset clears stage valid bits and sets data_bits to 4 (or MAX_DATA_BITS if smaller).
//  out_stall holds the output register; stall backs up stage by stage to in_stall.
`timescale 1ns / 1ps
`default_nettype none

`include "hamming_encode_and_correct_top_defines.svh"

module hamming_encode_and_correct_top #(
    parameter int MAX_DATA_BITS = 57
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write_en,
    input  wire logic [hec_pkg::POS_W-1:0]     cfg_write_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          opcode,
    input  wire logic [hec_pkg::MSG_W-1:0]     message,
    input  wire logic [hec_pkg::CW_W-1:0]      received,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [hec_pkg::CW_W-1:0]           codeword,
    output logic [hec_pkg::POS_W-1:0]          error_position,
    output logic [hec_pkg::STATUS_W-1:0]       status
);

    localparam int MW = MAX_DATA_BITS;
    localparam int NW = MAX_DATA_BITS + hec_pkg::parity_count(MAX_DATA_BITS);
    localparam int PW = hec_pkg::POS_W;

    hec_pkg::cfg_t cfg;

    logic          s1_valid;
    logic          s1_ready;
    logic          s1_op;
    logic [NW-1:0] s1_word;
    logic          s2_valid;
    logic          s2_ready;
    logic          s2_op;
    logic [NW-1:0] s2_word;
    logic [PW-1:0] s2_syn;

    hec_cfg #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cfg            (cfg)
    );

    hec_spread #(
        .MW (MW),
        .NW (NW)
    ) u_spread (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (in_valid),
        .up_stall   (in_stall),
        .opcode     (opcode),
        .message    (message),
        .received   (received),
        .down_valid (s1_valid),
        .down_ready (s1_ready),
        .down_op    (s1_op),
        .down_word  (s1_word)
    );

    hec_syndrome #(
        .NW (NW)
    ) u_syndrome (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_ready   (s1_ready),
        .up_op      (s1_op),
        .up_word    (s1_word),
        .down_valid (s2_valid),
        .down_ready (s2_ready),
        .down_op    (s2_op),
        .down_word  (s2_word),
        .down_syn   (s2_syn)
    );

    hec_correct #(
        .NW (NW)
    ) u_correct (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .up_valid       (s2_valid),
        .up_ready       (s2_ready),
        .up_op          (s2_op),
        .up_word        (s2_word),
        .up_syn         (s2_syn),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .codeword       (codeword),
        .error_position (error_position),
        .status         (status)
    );

    `HEC_ASSERT_IMPL(a_stall_needs_full_output, clk, rst_n, in_stall, out_valid && out_stall)
    `HEC_ASSERT_IMPL(a_clean_word_has_no_position, clk, rst_n, out_valid && (status == hec_pkg::STATUS_OK), error_position == '0)
    `HEC_ASSERT_NEVER(a_correction_without_position, clk, rst_n, out_valid && (status == hec_pkg::STATUS_CORRECTED) && (error_position == '0))
    `HEC_ASSERT_IMPL(a_stage_full_when_blocked, clk, rst_n, !s1_ready, s2_valid && out_valid)

endmodule

`default_nettype wire

// File: bench/hamming_encode_and_correct_top_tb.sv
// Self-checking testbench for the Hamming encode and correct block
`timescale 1ns / 1ps

module hamming_encode_and_correct_top_tb;

    localparam int MAX_K = 57;
    localparam int PHASES = 12;
    localparam int RANDOM_PER_PHASE = 55;

    typedef struct packed {
        logic                         op;
        logic [hec_pkg::MSG_W-1:0]    message;
        logic [hec_pkg::CW_W-1:0]     received;
    } hec_request_t;

    typedef struct packed {
        logic [hec_pkg::CW_W-1:0]     codeword;
        logic [hec_pkg::POS_W-1:0]    error_position;
        logic [hec_pkg::STATUS_W-1:0] status;
    } hec_answer_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write_en = 1'b0;
    logic [hec_pkg::POS_W-1:0]    cfg_write_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         opcode = hec_pkg::OP_ENCODE;
    logic [hec_pkg::MSG_W-1:0]    message = '0;
    logic [hec_pkg::CW_W-1:0]     received = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [hec_pkg::CW_W-1:0]     codeword;
    logic [hec_pkg::POS_W-1:0]    error_position;
    logic [hec_pkg::STATUS_W-1:0] status;

    hec_request_t                 pending_requests[$];
    hec_answer_t                  awaited_answers[$];
    logic [hec_pkg::POS_W-1:0]    data_bits_now = 6'd4;
    logic                         steady = 1'b0;
    int                           gap_left = 0;
    int                           stall_left = 0;
    int                           words_seen = 0;
    int                           errors = 0;

    hamming_encode_and_correct_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .message        (message),
        .received       (received),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .codeword       (codeword),
        .error_position (error_position),
        .status         (status)
    );

    function automatic logic [hec_pkg::POS_W-1:0] position_xor(
        input logic [hec_pkg::CW_W-1:0] w, input int n);
        logic [hec_pkg::POS_W-1:0] s;
        s = '0;
        for (int p = 1; p <= n; p++)
        begin
            if (w[p-1])
            begin
                s = s ^ hec_pkg::POS_W'(p);
            end
        end
        return s;
    endfunction

    function automatic hec_answer_t hamming_answer(input logic [hec_pkg::POS_W-1:0] k_reg,
                                                   input logic op,
                                                   input logic [hec_pkg::MSG_W-1:0] msg,
                                                   input logic [hec_pkg::CW_W-1:0] rcv);
        hec_answer_t               a;
        int                        k;
        int                        r;
        int                        n;
        int                        src;
        logic [hec_pkg::CW_W-1:0]  w;
        logic [hec_pkg::CW_W-1:0]  mask;
        logic [hec_pkg::POS_W-1:0] s;
        a = '0;
        k = int'(k_reg);
        if (k == 0)
        begin
            k = 1;
        end
        else if (k > MAX_K)
        begin
            k = MAX_K;
        end
        r = 0;
        while (r < 7 && (1 << r) < k + r + 1)
        begin
            r++;
        end
        n = k + r;
        mask = (hec_pkg::CW_W'(1) << n) - hec_pkg::CW_W'(1);
        if (op == hec_pkg::OP_ENCODE)
        begin
            w = '0;
            src = k - 1;
            for (int p = n; p >= 1 && src >= 0; p--)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    w[p-1] = msg[src];
                    src--;
                end
            end
            s = position_xor(w, n);
            for (int i = 0; i < r; i++)
            begin
                if (s[i])
                begin
                    w[(1 << i) - 1] = 1'b1;
                end
            end
            a.codeword = w & mask;
        end
        else
        begin
            w = rcv & mask;
            s = position_xor(w, n);
            if (s != 0 && int'(s) <= n)
            begin
                w[s-1] = ~w[s-1];
                a.status = hec_pkg::STATUS_CORRECTED;
            end
            else if (int'(s) > n)
            begin
                a.status = hec_pkg::STATUS_RANGE;
            end
            else
            begin
                a.status = hec_pkg::STATUS_OK;
            end
            a.codeword = w;
            a.error_position = s;
        end
        return a;
    endfunction

    function automatic logic [63:0] wide_random();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        hec_request_t req;
        logic         offer;
        int           gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            offer = in_valid;
            gap = gap_left;
            if (in_valid && !in_stall)
            begin
                awaited_answers.push_back(hamming_answer(data_bits_now, opcode, message,
                                                         received));
                offer = 1'b0;
                gap = steady ? 0 : $urandom_range(0, 3);
            end
            if (!offer)
            begin
                if (gap > 0)
                begin
                    gap--;
                end
                else if (pending_requests.size() > 0)
                begin
                    req = pending_requests.pop_front();
                    opcode <= req.op;
                    message <= req.message;
                    received <= req.received;
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
            gap_left <= gap;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_answers
        hec_answer_t want;
        int          hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            hold = stall_left;
            if (out_valid && !out_stall)
            begin
                if (awaited_answers.size() == 0)
                begin
                    $error("unexpected word: codeword %h", codeword);
                    errors++;
                end
                else
                begin
                    want = awaited_answers.pop_front();
                    if (codeword !== want.codeword)
                    begin
                        $error("codeword: expected %h, got %h", want.codeword, codeword);
                        errors++;
                    end
                    if (error_position !== want.error_position)
                    begin
                        $error("error_position: expected %0d, got %0d",
                               want.error_position, error_position);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        errors++;
                    end
                end
                words_seen++;
                // hold off long enough for the pipeline to back up into in_stall
                if (words_seen == 150 || words_seen == 700)
                begin
                    hold = 80;
                end
                else
                begin
                    hold = steady ? 0 : $urandom_range(0, 3);
                end
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
            stall_left = hold;
        end
    end

    initial
    begin : stimulus
        int unsigned      width_plan[PHASES];
        hec_request_t     req;
        hec_answer_t      enc;
        logic [63:0]      raw;
        int               kind;
        int               flip_at;
        width_plan = '{4, 5, 0, 1, 2, 57, 63, 58, 11, 26, 3, 32};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                while (pending_requests.size() != 0 || in_valid || awaited_answers.size() != 0)
                begin
                    @(negedge clk);
                end
                repeat (5) @(negedge clk);
                @(posedge clk);
                cfg_write_en <= 1'b1;
                cfg_write_data <= hec_pkg::POS_W'(width_plan[phase]);
                @(posedge clk);
                cfg_write_en <= 1'b0;
                data_bits_now = hec_pkg::POS_W'(width_plan[phase]);
            end
            @(negedge clk);
            steady = (phase % 4 == 2);
            if (phase == 0)
            begin
                pending_requests.push_back('{hec_pkg::OP_ENCODE, '0, '0});
                pending_requests.push_back('{hec_pkg::OP_DECODE, '0, '0});
            end
            pending_requests.push_back('{hec_pkg::OP_ENCODE, '1, '0});
            pending_requests.push_back('{hec_pkg::OP_DECODE, '0, '1});
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                kind = $urandom_range(0, 3);
                raw = wide_random();
                req.message = raw[hec_pkg::MSG_W-1:0];
                raw = wide_random();
                req.received = raw[hec_pkg::CW_W-1:0];
                if (kind <= 1)
                begin
                    // encode, then decode the codeword with at most one bit flipped
                    req.op = hec_pkg::OP_ENCODE;
                    pending_requests.push_back(req);
                    enc = hamming_answer(data_bits_now, hec_pkg::OP_ENCODE, req.message, '0);
                    flip_at = $urandom_range(0, hec_pkg::CW_W);
                    if (flip_at < hec_pkg::CW_W)
                    begin
                        enc.codeword[flip_at] = ~enc.codeword[flip_at];
                    end
                    req.op = hec_pkg::OP_DECODE;
                    req.received = enc.codeword;
                    pending_requests.push_back(req);
                end
                else
                begin
                    req.op = (kind == 2) ? hec_pkg::OP_ENCODE : hec_pkg::OP_DECODE;
                    pending_requests.push_back(req);
                end
            end
        end
        while (pending_requests.size() != 0 || in_valid || awaited_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
        if (errors == 0 && awaited_answers.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
